### sv/potq_pkg.sv
// potq_pkg: shared types, codes and sizes for the priority-ordered task queue
// depends on nothing; imported by every module of the block
package potq_pkg;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned IDX_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_DRAIN  = 2'd2,
    ACT_LIST   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_ENTRY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic {
    CMP_PRIO_GE = 1'b0,
    CMP_ID_EQ   = 1'b1
  } cmp_op_e;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] tm;
  } slot_t;

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    slot_t wr_data;
  } mem_req_t;

endpackage

### sv/potq_cmp.sv
// potq_cmp: the one compare unit shared by insert (priority) and remove (id)
// depends on potq_pkg
module potq_cmp
  import potq_pkg::*;
(
  input  cmp_op_e     op_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic        hit_o
);

  // priority compare uses the low byte only
  always_comb begin
    case (op_i)
      CMP_PRIO_GE: hit_o = (a_i[7:0] >= b_i[7:0]);
      CMP_ID_EQ:   hit_o = (a_i == b_i);
      default:     hit_o = 1'b0;
    endcase
  end

endmodule

### sv/potq_slot_mem.sv
// potq_slot_mem: slot store, one write and one registered read per cycle
// depends on potq_pkg
module potq_slot_mem
  import potq_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output slot_t    rd_data_o
);

  slot_t mem_q [QDEPTH];
  slot_t rd_data_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/priority_ordered_task_queue_core.sv
// priority_ordered_task_queue_core: sequencer around the slot store and compare unit
// depends on potq_pkg, potq_cmp, potq_slot_mem
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  command  | start_i, busy_o           | action_i, task_id_i, priority_req_i, exec_time_i
//  result   | result_valid_o (strobe)   | status_o, out_id_o, out_priority_o, out_time_o,
//           |                           | last_o
//
// one slot is read per cycle through the single store read port and the shared compare unit.
// insert: walks from the tail, moving lower priorities one slot back; insert into a full or an empty queue and
// remove/drain/list on an empty queue give their result in the next cycle without raising busy.
// remove: searches from the head for the id and pulls the tasks behind it forward.
// drain/list: one result per cycle after the first read.
// reset empties the queue at once; results cannot be stalled, a strobe lasts one cycle.
module priority_ordered_task_queue_core
  import potq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] task_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] exec_time_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] out_id_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_time_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_REM_FIND,
    S_REM_SHIFT,
    S_OUT
  } state_e;

  state_e      state_q, state_d;
  action_e     act_q, act_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  pr_q, pr_d;
  logic [15:0] tm_q, tm_d;
  idx_t        pos_q, pos_d;
  cnt_t        count_q, count_d;
  logic        res_valid_q, res_valid_d;
  status_e     status_q, status_d;
  slot_t       res_slot_q, res_slot_d;
  logic        last_q, last_d;

  mem_req_t    mem_req;
  slot_t       rdata;
  cmp_op_e     cmp_op;
  logic [15:0] cmp_a, cmp_b;
  logic        hit;
  idx_t        last_idx;
  slot_t       new_slot;

  potq_slot_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rdata)
  );

  // insert compares priorities, remove compares ids
  always_comb begin
    if (act_q == ACT_INSERT) begin
      cmp_op = CMP_PRIO_GE;
      cmp_a  = {8'h00, rdata.prio};
      cmp_b  = {8'h00, pr_q};
    end else begin
      cmp_op = CMP_ID_EQ;
      cmp_a  = rdata.id;
      cmp_b  = id_q;
    end
  end

  potq_cmp u_cmp (
    .op_i  (cmp_op),
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .hit_o (hit)
  );

  assign last_idx = idx_t'(count_q - cnt_t'(1));
  assign new_slot = '{id: id_q, prio: pr_q, tm: tm_q};

  // sequencer next state, store requests and result
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    id_d        = id_q;
    pr_d        = pr_q;
    tm_d        = tm_q;
    pos_d       = pos_q;
    count_d     = count_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    res_slot_d  = '0;
    last_d      = 1'b0;
    mem_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d = action_e'(action_i);
          id_d  = task_id_i;
          pr_d  = priority_req_i;
          tm_d  = exec_time_i;
          case (action_e'(action_i))
            ACT_INSERT: begin
              if (count_q == cnt_t'(QDEPTH)) begin
                res_valid_d = 1'b1;
                status_d    = ST_FULL;
                last_d      = 1'b1;
              end else if (count_q == '0) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = '{id: task_id_i, prio: priority_req_i, tm: exec_time_i};
                count_d     = cnt_t'(1);
                res_valid_d = 1'b1;
                status_d    = ST_DONE;
                last_d      = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = last_idx;
                pos_d   = last_idx;
                state_d = S_INS;
              end
            end
            ACT_REMOVE: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = ST_NOT_FOUND;
                last_d      = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                pos_d   = '0;
                state_d = S_REM_FIND;
              end
            end
            default: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = ST_EMPTY;
                last_d      = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                pos_d   = '0;
                state_d = S_OUT;
              end
            end
          endcase
        end
      end

      // walk from the tail, moving lower priorities one slot back
      S_INS: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_q + idx_t'(1);
        if (hit) begin
          mem_req.wr_data = new_slot;
          count_d     = count_q + cnt_t'(1);
          res_valid_d = 1'b1;
          status_d    = ST_DONE;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_req.wr_data = rdata;
          if (pos_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pos_q - idx_t'(1);
            pos_d = pos_q - idx_t'(1);
          end
        end
      end

      // new task goes to the head
      S_INS_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = '0;
        mem_req.wr_data = new_slot;
        count_d     = count_q + cnt_t'(1);
        res_valid_d = 1'b1;
        status_d    = ST_DONE;
        last_d      = 1'b1;
        state_d     = S_IDLE;
      end

      // search for the first matching id
      S_REM_FIND: begin
        if (pos_q == last_idx) begin
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          state_d     = S_IDLE;
          if (hit) begin
            status_d = ST_DONE;
            count_d  = count_q - cnt_t'(1);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = pos_q + idx_t'(1);
          pos_d = pos_q + idx_t'(1);
          if (hit) begin
            state_d = S_REM_SHIFT;
          end
        end
      end

      // pull the tasks behind the removed one forward
      S_REM_SHIFT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_q - idx_t'(1);
        mem_req.wr_data = rdata;
        if (pos_q == last_idx) begin
          count_d     = count_q - cnt_t'(1);
          res_valid_d = 1'b1;
          status_d    = ST_DONE;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = pos_q + idx_t'(1);
          pos_d = pos_q + idx_t'(1);
        end
      end

      // report each slot in order
      S_OUT: begin
        res_valid_d = 1'b1;
        status_d    = ST_ENTRY;
        res_slot_d  = rdata;
        if (pos_q == last_idx) begin
          last_d  = 1'b1;
          state_d = S_IDLE;
          if (act_q == ACT_DRAIN) begin
            count_d = '0;
          end
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = pos_q + idx_t'(1);
          pos_d = pos_q + idx_t'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_INSERT;
      id_q        <= '0;
      pr_q        <= '0;
      tm_q        <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      res_slot_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      id_q        <= id_d;
      pr_q        <= pr_d;
      tm_q        <= tm_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      status_q    <= status_d;
      res_slot_q  <= res_slot_d;
      last_q      <= last_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign out_id_o       = res_slot_q.id;
  assign out_priority_o = res_slot_q.prio;
  assign out_time_o     = res_slot_q.tm;
  assign last_o         = last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(QDEPTH))
    else $error("task count beyond queue depth");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o)
    else $error("final result while still busy");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("non-final result with sequencer idle");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && act_q == ACT_DRAIN && pos_q == last_idx) |=> count_q == '0)
    else $error("drain left tasks in queue");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == ACT_INSERT && count_q == cnt_t'(QDEPTH))
      |=> (result_valid_o && status_o == ST_FULL))
    else $error("insert on full queue not reported as dropped");
`endif

endmodule

### dv/priority_ordered_task_queue_core_tb.sv
// priority_ordered_task_queue_core_tb: self-checking bench for the sorted task queue core
// depends on potq_pkg and priority_ordered_task_queue_core; every result strobe is checked
// against a behavioural copy of the sorted slots kept in a small scoreboard class
module priority_ordered_task_queue_core_tb;
  import potq_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] tm;
    logic        last;
  } task_report_t;

  // scoreboard: mirrors the queue contents and holds the reports still owed by the core
  class task_queue_checker;
    slot_t        slots[QDEPTH];
    int unsigned  n_tasks = 0;
    task_report_t expected_reports[$];
    int unsigned  mismatches = 0;

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void push_report(status_e st, slot_t s, logic lst);
      task_report_t r;
      r.status = st;
      r.id     = s.id;
      r.prio   = s.prio;
      r.tm     = s.tm;
      r.last   = lst;
      expected_reports.push_back(r);
    endfunction

    // work out the reports of one accepted command and update the slot copy
    function void note_command(action_e act, logic [15:0] id, logic [7:0] pr,
                               logic [15:0] tm);
      int unsigned pos;
      slot_t       blank;
      blank = '0;
      case (act)
        ACT_INSERT: begin
          if (n_tasks >= QDEPTH) begin
            push_report(ST_FULL, blank, 1'b1);
          end else begin
            // new task goes behind every task of equal or higher priority
            pos = 0;
            while (pos < n_tasks && slots[pos].prio >= pr) pos++;
            for (int unsigned i = n_tasks; i > pos; i--) slots[i] = slots[i-1];
            slots[pos].id   = id;
            slots[pos].prio = pr;
            slots[pos].tm   = tm;
            n_tasks++;
            push_report(ST_DONE, blank, 1'b1);
          end
        end
        ACT_REMOVE: begin
          pos = 0;
          while (pos < n_tasks && slots[pos].id != id) pos++;
          if (pos >= n_tasks) begin
            push_report(ST_NOT_FOUND, blank, 1'b1);
          end else begin
            for (int unsigned i = pos; i + 1 < n_tasks; i++) slots[i] = slots[i+1];
            n_tasks--;
            push_report(ST_DONE, blank, 1'b1);
          end
        end
        default: begin
          // drain and list report every task in queue order
          if (n_tasks == 0) begin
            push_report(ST_EMPTY, blank, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n_tasks; i++)
              push_report(ST_ENTRY, slots[i], (i + 1 == n_tasks));
            if (act == ACT_DRAIN) n_tasks = 0;
          end
        end
      endcase
    endfunction

    // compare one observed report with the oldest one owed
    function void check_report(task_report_t seen);
      task_report_t want;
      if (expected_reports.size() == 0) begin
        flag($sformatf("unexpected report: status %0d id %h prio %h time %h last %b",
                       seen.status, seen.id, seen.prio, seen.tm, seen.last));
        return;
      end
      want = expected_reports.pop_front();
      if (seen.status !== want.status || seen.id !== want.id || seen.prio !== want.prio ||
          seen.tm !== want.tm || seen.last !== want.last)
        flag($sformatf({"expected status %0d id %h prio %h time %h last %b, ",
                        "got status %0d id %h prio %h time %h last %b"},
                       want.status, want.id, want.prio, want.tm, want.last,
                       seen.status, seen.id, seen.prio, seen.tm, seen.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  action_i;
  logic [15:0] task_id_i;
  logic [7:0]  priority_req_i;
  logic [15:0] exec_time_i;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [15:0] out_id_o;
  logic [7:0]  out_priority_o;
  logic [15:0] out_time_o;
  logic        last_o;

  task_queue_checker sb;
  task_report_t      observed;
  int unsigned       idle_pct;

  priority_ordered_task_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .exec_time_i    (exec_time_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .out_time_o     (out_time_o),
    .last_o         (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result monitor: a strobe is a transfer, no back-pressure exists
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      observed.status = status_e'(status_o);
      observed.id     = out_id_o;
      observed.prio   = out_priority_o;
      observed.tm     = out_time_o;
      observed.last   = last_o;
      sb.check_report(observed);
    end
  end

  // one command transfer, with an optional idle gap in front; start stays high on exit
  task automatic issue(action_e act, logic [15:0] id, logic [7:0] pr, logic [15:0] tm);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    action_i       <= act;
    task_id_i      <= id;
    priority_req_i <= pr;
    exec_time_i    <= tm;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(act, id, pr, tm);
  endtask

  // mostly inserts and removes of live ids, with lists and the odd drain
  task automatic random_commands(int unsigned count);
    int unsigned pick;
    logic [15:0] id;
    logic [7:0]  pr;
    logic [15:0] tm;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      id   = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 7));
      pr   = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
      tm   = 16'($urandom_range(0, 65535));
      if (pick < 60) begin
        issue(ACT_INSERT, id, pr, tm);
      end else if (pick < 80) begin
        if (sb.n_tasks != 0 && $urandom_range(0, 99) < 75)
          id = sb.slots[$urandom_range(0, sb.n_tasks - 1)].id;
        issue(ACT_REMOVE, id, pr, tm);
      end else if (pick < 92 || (sb.n_tasks < 10 && $urandom_range(0, 3) != 0)) begin
        issue(ACT_LIST, id, pr, tm);
      end else begin
        issue(ACT_DRAIN, id, pr, tm);
      end
    end
  endtask

  // stimulus
  initial begin
    sb             = new;
    idle_pct       = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    action_i       = ACT_INSERT;
    task_id_i      = '0;
    priority_req_i = '0;
    exec_time_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty queue on every action that reads it
    issue(ACT_LIST, 16'h0000, 8'h00, 16'h0000);
    issue(ACT_DRAIN, 16'hffff, 8'hff, 16'hffff);
    issue(ACT_REMOVE, 16'h0000, 8'h00, 16'h0000);
    // field extremes and a tie on priority
    issue(ACT_INSERT, 16'h0000, 8'h00, 16'h0000);
    issue(ACT_INSERT, 16'hffff, 8'hff, 16'hffff);
    issue(ACT_INSERT, 16'h1234, 8'h80, 16'h5555);
    issue(ACT_INSERT, 16'h0002, 8'h80, 16'haaaa);
    issue(ACT_LIST, 16'h0000, 8'h00, 16'h0000);
    // remove from the middle, a missing id and the head
    issue(ACT_REMOVE, 16'h1234, 8'h00, 16'h0000);
    issue(ACT_REMOVE, 16'h9999, 8'h00, 16'h0000);
    issue(ACT_REMOVE, 16'hffff, 8'h00, 16'h0000);
    // fill up with repeated ids, then overflow
    for (int i = 0; i < 14; i++)
      issue(ACT_INSERT, 16'(i % 3), 8'(i * 19), 16'(i * 4099));
    issue(ACT_INSERT, 16'h7777, 8'h40, 16'h1111);
    issue(ACT_REMOVE, 16'h0002, 8'h00, 16'h0000);
    issue(ACT_DRAIN, 16'h0000, 8'h00, 16'h0000);
    issue(ACT_LIST, 16'h0000, 8'h00, 16'h0000);

    // random part in phases of sender idling
    idle_pct = 0;
    random_commands(47);
    idle_pct = 72;
    random_commands(47);
    idle_pct = 16;
    random_commands(47);
    start_i <= 1'b0;

    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (QDEPTH + 4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
